// ===== rtl/hmp_pkg.sv =====
package hmp_pkg;

  localparam int unsigned NUM_BUCKETS = 1024;
  localparam int unsigned WAYS        = 4;
  localparam int unsigned KEY_W       = 31;
  localparam int unsigned VALUE_W     = 31;
  // bucket = key mod NUM_BUCKETS, taken as the low key bits (power of two)
  localparam int unsigned BUCKET_W    = $clog2(NUM_BUCKETS);

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [1:0]         command;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] read_value;
    logic               status;
  } out_word_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic clear_en;
    logic load;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_full;
  } dp_status_t;

endpackage

// ===== rtl/hmp_ctrl.sv =====
module hmp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hmp_pkg::dp_status_t status_i,
  output hmp_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!status_i.out_full) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

endmodule

// ===== rtl/hmp_datapath.sv =====
module hmp_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hmp_pkg::ctrl_cmd_t  cmd_i,
  output hmp_pkg::dp_status_t status_o,
  input  hmp_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hmp_pkg::out_word_t  out_word_o
);

  hmp_pkg::row_t                      mem [hmp_pkg::NUM_BUCKETS];
  hmp_pkg::row_t                      rdata_q;
  hmp_pkg::in_word_t                  item_q;
  logic [hmp_pkg::BUCKET_W-1:0]       clr_addr_q;
  logic                               out_valid_q;
  hmp_pkg::out_word_t                 out_q;

  logic [hmp_pkg::BUCKET_W-1:0]       item_bucket;
  logic [hmp_pkg::BUCKET_W-1:0]       waddr;
  logic [hmp_pkg::WAYS-1:0]           hit_sel;
  logic [hmp_pkg::WAYS-1:0]           free_sel;
  logic                               hit_any;
  logic                               free_any;
  logic [hmp_pkg::VALUE_W-1:0]        hit_value;
  hmp_pkg::row_t                      row_new;
  logic                               row_change;
  logic                               we;
  hmp_pkg::row_t                      wdata;
  hmp_pkg::out_word_t                 result;

  assign item_bucket = item_q.key[hmp_pkg::BUCKET_W-1:0];

  // way search: first matching valid entry, first free entry
  always_comb begin
    hit_sel   = '0;
    free_sel  = '0;
    hit_any   = 1'b0;
    free_any  = 1'b0;
    hit_value = '0;
    for (int w = 0; w < hmp_pkg::WAYS; w++) begin
      if (rdata_q[w].valid) begin
        if (rdata_q[w].key == item_q.key && !hit_any) begin
          hit_sel[w] = 1'b1;
          hit_any    = 1'b1;
          hit_value  = rdata_q[w].value;
        end
      end else if (!free_any) begin
        free_sel[w] = 1'b1;
        free_any    = 1'b1;
      end
    end
  end

  always_comb begin
    row_new    = rdata_q;
    row_change = 1'b0;
    result     = '0;
    case (item_q.command)
      hmp_pkg::CMD_PUT: begin
        row_change = 1'b1;
        if (hit_any) begin
          result.found = 1'b1;
          for (int w = 0; w < hmp_pkg::WAYS; w++) begin
            if (hit_sel[w]) begin
              row_new[w].value = item_q.value;
            end
          end
        end else if (free_any) begin
          for (int w = 0; w < hmp_pkg::WAYS; w++) begin
            if (free_sel[w]) begin
              row_new[w].valid = 1'b1;
              row_new[w].key   = item_q.key;
              row_new[w].value = item_q.value;
            end
          end
        end else begin
          row_change    = 1'b0;
          result.status = hmp_pkg::STATUS_FULL;
        end
      end
      hmp_pkg::CMD_GET: begin
        result.found      = hit_any;
        result.read_value = hit_value;
      end
      hmp_pkg::CMD_REMOVE: begin
        result.found = hit_any;
        row_change   = hit_any;
        for (int w = 0; w < hmp_pkg::WAYS; w++) begin
          if (hit_sel[w]) begin
            row_new[w].valid = 1'b0;
          end
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  assign we    = cmd_i.clear_en | (cmd_i.commit & row_change);
  assign waddr = cmd_i.clear_en ? clr_addr_q : item_bucket;
  assign wdata = cmd_i.clear_en ? hmp_pkg::row_t'('0) : row_new;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.load) begin
      rdata_q <= mem[in_word_i.key[hmp_pkg::BUCKET_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_word_i;
    end
    if (cmd_i.commit) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_en) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.clear_last = cmd_i.clear_en && (clr_addr_q == '1);
  assign status_o.out_full   = out_valid_q && !out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign out_word_o          = out_q;

endmodule

// ===== rtl/hash_map_put_get_remove_core.sv =====
// Channel  Direction  Handshake                 Word
// in       input      in_valid_i / in_ready_o   in_word_i  (command, key, value)
// out      output     out_valid_o / out_ready_i out_word_o (found, read_value, status)
//
// The bucket row is read from the single memory into a register in the accept
// cycle, then compared across all ways and written back in the lookup state;
// no new word is accepted before that. After reset a clearing pass writes
// every row with in_ready_o low. One result word is held in an output register;
// a stalled output holds the next word in its lookup cycle until the register frees.
module hash_map_put_get_remove_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hmp_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hmp_pkg::out_word_t out_word_o
);

  hmp_pkg::ctrl_cmd_t  cmd;
  hmp_pkg::dp_status_t status;

  hmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hmp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [hmp_pkg::KEY_W-1:0]   key_t;
  typedef logic [hmp_pkg::VALUE_W-1:0] val_t;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned SLOTS     = hmp_pkg::NUM_BUCKETS * hmp_pkg::WAYS;
  localparam int unsigned LIMIT     = 300000;
  localparam int unsigned HOLD_LEN  = 400;
  localparam int unsigned TAIL      = 20;
  localparam key_t KEY_MAX = '1;
  localparam val_t VAL_MAX = '1;

  logic               clk_i;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  hmp_pkg::in_word_t  in_word   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  hmp_pkg::out_word_t out_word;

  hash_map_put_get_remove_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  // shadow copy of the bucket store
  logic shadow_vld [SLOTS];
  key_t shadow_key [SLOTS];
  val_t shadow_val [SLOTS];

  hmp_pkg::in_word_t  pending_words [$];
  hmp_pkg::out_word_t expected_words [$];

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  logic        pressure_on = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned n_cmd [4] = '{0, 0, 0, 0};
  int unsigned n_hit = 0;
  int unsigned n_full = 0;
  int unsigned n_seen = 0;
  hmp_pkg::out_word_t want;

  int unsigned hot_bkt [8] = '{0, 1, 7, 100, 300, hmp_pkg::NUM_BUCKETS / 2,
                               hmp_pkg::NUM_BUCKETS - 2, hmp_pkg::NUM_BUCKETS - 1};

  function automatic hmp_pkg::out_word_t map_apply(hmp_pkg::in_word_t w);
    hmp_pkg::out_word_t r;
    int unsigned        base;
    int                 hit;
    int                 free_way;
    r        = '0;
    hit      = -1;
    free_way = -1;
    base     = (w.key % hmp_pkg::NUM_BUCKETS) * hmp_pkg::WAYS;
    for (int i = 0; i < hmp_pkg::WAYS; i++) begin
      if (shadow_vld[base + i]) begin
        if (shadow_key[base + i] == w.key && hit < 0) hit = i;
      end else if (free_way < 0) begin
        free_way = i;
      end
    end
    case (w.command)
      hmp_pkg::CMD_PUT: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          shadow_val[base + hit] = w.value;
        end else if (free_way >= 0) begin
          shadow_vld[base + free_way] = 1'b1;
          shadow_key[base + free_way] = w.key;
          shadow_val[base + free_way] = w.value;
        end else begin
          r.status = hmp_pkg::STATUS_FULL;
        end
      end
      hmp_pkg::CMD_GET: begin
        if (hit >= 0) begin
          r.found      = 1'b1;
          r.read_value = shadow_val[base + hit];
        end
      end
      hmp_pkg::CMD_REMOVE: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          shadow_vld[base + hit] = 1'b0;
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic push_word(logic [1:0] c, key_t k, val_t v);
    hmp_pkg::in_word_t w;
    w.command = c;
    w.key     = k;
    w.value   = v;
    pending_words = {pending_words, w};
  endtask

  function automatic key_t pick_key();
    key_t k;
    if ($urandom_range(99) < 12) begin
      k = key_t'($urandom);
    end else begin
      k = (key_t'($urandom_range(0, 6)) << hmp_pkg::BUCKET_W) |
          key_t'(hot_bkt[$urandom_range(0, 7)]);
    end
    return k;
  endfunction

  function automatic val_t pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return VAL_MAX;
    return val_t'($urandom);
  endfunction

  task automatic push_random(int unsigned count);
    int unsigned r;
    logic [1:0]  c;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 40)      c = hmp_pkg::CMD_PUT;
      else if (r < 70) c = hmp_pkg::CMD_GET;
      else if (r < 95) c = hmp_pkg::CMD_REMOVE;
      else             c = CMD_UNUSED;
      push_word(c, pick_key(), pick_value());
    end
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_valid) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_word  <= '0;
    end else if (in_valid && !in_ready) begin
      in_valid <= 1'b1;
    end else begin
      if (in_valid) begin
        expected_words = {expected_words, map_apply(in_word)};
        n_cmd[in_word.command]++;
      end
      if (pending_words.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_valid <= 1'b1;
        in_word  <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long output hold-off, once
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (pressure_on && !hold_done) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word found=%0d read_value=%h status=%0d", $time,
                   out_word.found, out_word.read_value, out_word.status);
        end else begin
          want = expected_words.pop_front();
          n_seen++;
          if (want.found) n_hit++;
          if (want.status == hmp_pkg::STATUS_FULL) n_full++;
          if (out_word.found !== want.found) begin
            errors++;
            $display("%0t: found mismatch: expected %0d, actual %0d", $time,
                     want.found, out_word.found);
          end
          if (out_word.read_value !== want.read_value) begin
            errors++;
            $display("%0t: read_value mismatch: expected %h, actual %h", $time,
                     want.read_value, out_word.read_value);
          end
          if (out_word.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                     want.status, out_word.status);
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, expected_words.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      shadow_vld[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_val[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed
    push_word(hmp_pkg::CMD_PUT, '0, '0);
    push_word(hmp_pkg::CMD_GET, '0, VAL_MAX);
    push_word(hmp_pkg::CMD_PUT, KEY_MAX, VAL_MAX);
    push_word(hmp_pkg::CMD_GET, KEY_MAX, '0);
    push_word(hmp_pkg::CMD_PUT, '0, 31'h5555_5555);
    push_word(hmp_pkg::CMD_GET, '0, '0);
    push_word(hmp_pkg::CMD_GET, key_t'(hmp_pkg::NUM_BUCKETS), 31'h2aaa_aaaa);
    push_word(hmp_pkg::CMD_REMOVE, 31'd3, '0);
    for (int i = 0; i <= hmp_pkg::WAYS; i++)
      push_word(hmp_pkg::CMD_PUT, key_t'(7 + i * hmp_pkg::NUM_BUCKETS), val_t'(100 + i));
    push_word(hmp_pkg::CMD_REMOVE, key_t'(7 + hmp_pkg::NUM_BUCKETS), '0);
    push_word(hmp_pkg::CMD_PUT, key_t'(7 + hmp_pkg::WAYS * hmp_pkg::NUM_BUCKETS), 31'd999);
    push_word(hmp_pkg::CMD_GET, key_t'(7 + hmp_pkg::NUM_BUCKETS), '0);
    push_word(hmp_pkg::CMD_GET, key_t'(7 + hmp_pkg::WAYS * hmp_pkg::NUM_BUCKETS), '0);
    push_word(CMD_UNUSED, 31'd7, VAL_MAX);
    push_word(hmp_pkg::CMD_GET, 31'd7, '0);
    push_word(hmp_pkg::CMD_REMOVE, '0, '0);
    push_word(hmp_pkg::CMD_GET, '0, '0);
    drain();

    push_random(300);
    drain();
    snd_idle_pct = 48;
    push_random(300);
    drain();
    snd_idle_pct  = 0;
    rcv_stall_pct = 48;
    push_random(300);
    drain();
    snd_idle_pct  = 22;
    rcv_stall_pct = 22;
    push_random(300);
    drain();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    pressure_on   = 1'b1;
    push_random(300);
    drain();

    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    $display("Checked %0d words: %0d put, %0d get, %0d remove, %0d unused code;",
             n_seen, n_cmd[hmp_pkg::CMD_PUT], n_cmd[hmp_pkg::CMD_GET],
             n_cmd[hmp_pkg::CMD_REMOVE], n_cmd[CMD_UNUSED]);
    $display("%0d hits, %0d full-bucket drops, idle/stall phases and a %0d-cycle output hold.",
             n_hit, n_full, HOLD_LEN);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
